// File: hw/rtl/tcce_pkg.sv
// ============================================================================
// tcce_pkg - shared types and constants for the text console cursor engine
// Escape parser phases, result operation codes, register indexes and the
// result word layout used by the engine and its result queue.
// ============================================================================
package tcce_pkg;

	// field widths
	localparam int BYTE_W    = 8;
	localparam int OP_W      = 2;
	localparam int NIB_W     = 4;
	localparam int PHASE_W   = 3;
	localparam int CFG_IDX_W = 2;

	// tab stop spacing in columns
	localparam int TAB_STOP = 8;

	// results per input byte at most, and result queue depth
	localparam int RES_MAX    = 3;
	localparam int RES_CNT_W  = 2;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd2;

	// register reset values
	localparam logic [BYTE_W-1:0] COLUMNS_RST = 8'd80;
	localparam logic [BYTE_W-1:0] ROWS_RST    = 8'd25;
	localparam logic [BYTE_W-1:0] COLOR_RST   = 8'h07;

	// escape parser phases
	localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_CMD   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_COLOR = 3'd2;
	localparam logic [PHASE_W-1:0] PH_XPOS  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_YPOS  = 3'd4;

	// result operations
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_SCROLL = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;
	localparam logic [OP_W-1:0] OP_REPORT = 2'd3;

	// special bytes
	localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] ESC_CLR  = 8'd33;
	localparam logic [BYTE_W-1:0] ESC_COL  = 8'd34;
	localparam logic [BYTE_W-1:0] ESC_POS  = 8'd35;

	// one result word
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] col;
		logic [BYTE_W-1:0] row;
		logic [BYTE_W-1:0] glyph;
		logic [NIB_W-1:0]  fg;
		logic [NIB_W-1:0]  bg;
		logic              vis;
		logic              last;
	} result_t;

	// build a result word; colors come from the current text color
	function automatic result_t mk_res(
		input logic [OP_W-1:0]   op,
		input logic [BYTE_W-1:0] col,
		input logic [BYTE_W-1:0] row,
		input logic [BYTE_W-1:0] glyph,
		input logic [BYTE_W-1:0] color,
		input logic              vis,
		input logic              last
	);
		result_t r;
		r.op    = op;
		r.col   = col;
		r.row   = row;
		r.glyph = glyph;
		r.fg    = color[NIB_W-1:0];
		r.bg    = color[BYTE_W-1:NIB_W];
		r.vis   = vis;
		r.last  = last;
		return r;
	endfunction

endpackage

// File: hw/rtl/text_console_cursor_engine.sv
// ============================================================================
// text_console_cursor_engine - console byte stream to screen commands
// Tracks cursor, text color and escape parser phase; each byte yields
// scrolls, a clear or a cell write when needed, then a cursor report.
// ============================================================================
//
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+----------------------
//  data     | data_valid, data_ready, data_byte         | byte in
//  result   | result_valid, result_ready, operation,    | command words out
//           | col, row, glyph, fg_color, bg_color,      |
//           | cursor_visible, last                      |
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes
//
// A byte is registered, then processed against the cursor state; its 1 to 3
// words go into a 4-entry result queue. The result port drains one word per
// cycle while result_ready is high. The byte stage commits only when the
// queue has room for three words; a stalled result port therefore holds the
// byte stage and then data_ready.
// Reset clears the cursor, color 0x07, parser idle, registers to 80x25 on.
// cfg_ready is always high.

module text_console_cursor_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                data_valid,
	output logic                                data_ready,
	input  logic [tcce_pkg::BYTE_W-1:0]         data_byte,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [tcce_pkg::OP_W-1:0]           operation,
	output logic [tcce_pkg::BYTE_W-1:0]         col,
	output logic [tcce_pkg::BYTE_W-1:0]         row,
	output logic [tcce_pkg::BYTE_W-1:0]         glyph,
	output logic [tcce_pkg::NIB_W-1:0]          fg_color,
	output logic [tcce_pkg::NIB_W-1:0]          bg_color,
	output logic                                cursor_visible,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tcce_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tcce_pkg::BYTE_W-1:0]         cfg_data
);
	import tcce_pkg::*;

	// configuration registers
	logic [BYTE_W-1:0]  columns_q;
	logic [BYTE_W-1:0]  rows_q;
	logic               enable_q;

	// console state
	logic [BYTE_W-1:0]  cur_col_q;
	logic [BYTE_W-1:0]  cur_row_q;
	logic [BYTE_W-1:0]  color_q;
	logic [PHASE_W-1:0] phase_q;
	logic [BYTE_W-1:0]  pend_x_q;

	// byte stage
	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;

	// result queue
	result_t                fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [FIFO_CNT_W-1:0]  count_q;

	// next state and words of the byte in stage 1
	logic [BYTE_W-1:0]  nx_col;
	logic [BYTE_W-1:0]  nx_row;
	logic [BYTE_W-1:0]  nx_color;
	logic [PHASE_W-1:0] nx_phase;
	logic [BYTE_W-1:0]  nx_pend_x;
	result_t            res [RES_MAX];
	logic [RES_CNT_W-1:0] n_res;
	logic [BYTE_W:0]    tab_col;

	logic               pop;
	logic               commit;
	logic [FIFO_CNT_W-1:0] count_left;

	// ---- configuration port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RST;
			rows_q    <= ROWS_RST;
			enable_q  <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COLUMNS: columns_q <= cfg_data;
				REG_ROWS:    rows_q    <= cfg_data;
				REG_ENABLE:  enable_q  <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	// ---- queue handshake
	assign pop        = result_valid && result_ready;
	assign count_left = count_q - FIFO_CNT_W'(pop);
	// room for a full byte's worth of words after this cycle's pop
	assign commit     = valid_s1 && (count_left <= FIFO_CNT_W'(FIFO_DEPTH - RES_MAX));
	assign data_ready = !valid_s1 || commit;

	// ---- byte stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_valid && data_ready) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && data_ready) begin
			byte_s1 <= data_byte;
		end
	end

	// ---- byte processing: parser, cursor moves and word build
	always_comb begin
		nx_col    = cur_col_q;
		nx_row    = cur_row_q;
		nx_color  = color_q;
		nx_phase  = phase_q;
		nx_pend_x = pend_x_q;
		n_res     = '0;
		tab_col   = '0;
		for (int i = 0; i < RES_MAX; i++) begin
			res[i] = '0;
		end

		case (phase_q)
			PH_CMD: begin
				nx_phase = PH_IDLE;
				if (byte_s1 == ESC_CLR) begin
					if (enable_q) begin
						nx_col   = '0;
						nx_row   = '0;
						nx_color = COLOR_RST;
						res[n_res] = mk_res(OP_CLEAR, '0, '0, '0, nx_color, 1'b0, 1'b0);
						n_res = n_res + 1'b1;
					end
				end else if (byte_s1 == ESC_COL) begin
					nx_phase = PH_COLOR;
				end else if (byte_s1 == ESC_POS) begin
					nx_phase = PH_XPOS;
				end
			end
			PH_COLOR: begin
				nx_color = byte_s1;
				nx_phase = PH_IDLE;
			end
			PH_XPOS: begin
				nx_pend_x = byte_s1;
				nx_phase  = PH_YPOS;
			end
			PH_YPOS: begin
				// out of range coordinates fall back to zero
				nx_col   = (pend_x_q < columns_q) ? pend_x_q : '0;
				nx_row   = (byte_s1 < rows_q) ? byte_s1 : '0;
				nx_phase = PH_IDLE;
			end
			default: begin
				nx_phase = PH_IDLE;
				if (byte_s1 == CH_ESC) begin
					nx_phase = PH_CMD;
				end else if (enable_q) begin
					// deferred scroll from a previous byte
					if (nx_row == rows_q) begin
						res[n_res] = mk_res(OP_SCROLL, '0, '0, '0, nx_color, 1'b0, 1'b0);
						n_res  = n_res + 1'b1;
						nx_row = nx_row - 1'b1;
					end
					case (byte_s1)
						CH_LF: begin
							nx_col = '0;
							nx_row = nx_row + 1'b1;
							if (nx_row == rows_q) begin
								res[n_res] = mk_res(OP_SCROLL, '0, '0, '0, nx_color,
									1'b0, 1'b0);
								n_res  = n_res + 1'b1;
								nx_row = nx_row - 1'b1;
							end
						end
						CH_CR: begin
							nx_col = '0;
						end
						CH_BS: begin
							// top left: nothing moves, nothing is blanked
							if (!(nx_col == '0 && nx_row == '0)) begin
								if (nx_col == '0) begin
									nx_row = nx_row - 1'b1;
									nx_col = columns_q;
								end
								nx_col = nx_col - 1'b1;
								res[n_res] = mk_res(OP_WRITE, nx_col, nx_row, '0, nx_color,
									1'b0, 1'b0);
								n_res = n_res + 1'b1;
							end
						end
						CH_TAB: begin
							tab_col = (BYTE_W+1)'(({1'b0, nx_col} / (BYTE_W+1)'(TAB_STOP)
								+ 1'b1) * (BYTE_W+1)'(TAB_STOP));
							if (tab_col >= {1'b0, columns_q}) begin
								nx_row = nx_row + 1'b1;
								nx_col = BYTE_W'(tab_col - {1'b0, columns_q});
								if (nx_row == rows_q) begin
									res[n_res] = mk_res(OP_SCROLL, '0, '0, '0, nx_color,
										1'b0, 1'b0);
									n_res  = n_res + 1'b1;
									nx_row = nx_row - 1'b1;
								end
							end else begin
								nx_col = tab_col[BYTE_W-1:0];
							end
						end
						default: begin
							res[n_res] = mk_res(OP_WRITE, nx_col, nx_row, byte_s1, nx_color,
								1'b0, 1'b0);
							n_res  = n_res + 1'b1;
							nx_col = nx_col + 1'b1;
							if (nx_col == columns_q) begin
								nx_col = '0;
								nx_row = nx_row + 1'b1;
							end
						end
					endcase
				end
			end
		endcase

		// closing cursor report
		res[n_res] = mk_res(OP_REPORT, nx_col, nx_row, '0, nx_color,
			(nx_row < rows_q) && (nx_col < columns_q), 1'b1);
		n_res = n_res + 1'b1;
	end

	// ---- console state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			color_q   <= COLOR_RST;
			phase_q   <= PH_IDLE;
			pend_x_q  <= '0;
		end else if (commit) begin
			cur_col_q <= nx_col;
			cur_row_q <= nx_row;
			color_q   <= nx_color;
			phase_q   <= nx_phase;
			pend_x_q  <= nx_pend_x;
		end
	end

	// ---- result queue storage: a committed byte fills n_res slots from wr_ptr
	for (genvar g = 0; g < FIFO_DEPTH; g++) begin : g_slot
		logic [FIFO_PTR_W-1:0] off;
		assign off = FIFO_PTR_W'(g) - wr_ptr_q;
		always_ff @(posedge clk) begin
			if (commit && ({1'b0, off} < {1'b0, n_res})) begin
				fifo_q[g] <= res[off];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (commit) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_left + (commit ? FIFO_CNT_W'(n_res) : '0);
		end
	end

	// ---- result port, driven from the queue head
	assign result_valid   = (count_q != '0);
	assign operation      = fifo_q[rd_ptr_q].op;
	assign col            = fifo_q[rd_ptr_q].col;
	assign row            = fifo_q[rd_ptr_q].row;
	assign glyph          = fifo_q[rd_ptr_q].glyph;
	assign fg_color       = fifo_q[rd_ptr_q].fg;
	assign bg_color       = fifo_q[rd_ptr_q].bg;
	assign cursor_visible = fifo_q[rd_ptr_q].vis;
	assign last           = fifo_q[rd_ptr_q].last;

	// ---- checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("result queue over capacity");

	a_commit_words: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> result_valid)
		else $error("committed byte left no word in the queue");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> data_ready)
		else $error("byte input stalled with an empty result queue");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> ({1'b0, count_left} + {2'b0, n_res} <= (FIFO_CNT_W+1)'(FIFO_DEPTH)))
		else $error("committed words overrun the result queue");

endmodule
